/* rtl/grfp_pkg.sv */
`default_nettype none

package grfp_pkg;

  localparam int COORD_BITS = 12;

  localparam int CH_W      = 8;
  localparam int SUM_W     = CH_W + 2;
  localparam int CX_W      = 12;
  localparam int RAD_W     = 13;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 13;
  localparam int FRAC_BITS = 8;

  // squared distance, then shifted up by two fraction-bit widths for the root
  localparam int SQR_W     = 2 * COORD_BITS;
  localparam int D2_W      = SQR_W + 1;
  localparam int V_W       = D2_W + 2 * FRAC_BITS;
  localparam int SQ_K      = (V_W + 1) / 2;
  localparam int SQ_V_W    = 2 * SQ_K;
  localparam int SQ_REM_W  = SQ_K + 2;

  localparam int RF_W      = RAD_W + FRAC_BITS;
  localparam int CMP_W     = (SQ_K > RF_W) ? SQ_K : RF_W;
  localparam int NUM_W     = SUM_W + RF_W;
  localparam int DEN_W     = RF_W + 2;
  localparam int Q_W       = CH_W;
  localparam int DSH_W     = DEN_W + Q_W - 1;

  // front stages (3) + root cells + scale stage (1) + divider cells
  localparam int PIPE_LAT  = 4 + SQ_K + Q_W;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CENTER_X    = 2'd0,
    REG_CENTER_Y    = 2'd1,
    REG_FADE_RADIUS = 2'd2
  } cfg_reg_t;

  typedef struct packed {
    logic [SQ_REM_W-1:0] rem;
    logic [SQ_K-1:0]     root;
    logic [SQ_V_W-1:0]   rad;
    logic [SUM_W-1:0]    sum;
  } sq_data_t;

  typedef struct packed {
    logic [NUM_W-1:0] rem;
    logic [DSH_W-1:0] dsh;
    logic [Q_W-1:0]   quo;
  } div_data_t;

endpackage

`default_nettype wire

/* rtl/grfp_sqrt_cell.sv */
`default_nettype none

module grfp_sqrt_cell (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  grfp_pkg::sq_data_t in_data,
  output logic               out_valid,
  output grfp_pkg::sq_data_t out_data
);
  import grfp_pkg::*;

  logic [SQ_REM_W+1:0] rem_sh;
  logic [SQ_REM_W+1:0] trial;
  logic                fits;
  sq_data_t            data_nxt;
  logic                valid_r;
  sq_data_t            data_r;

  always_comb begin
    // bring down the next two radicand bits, try root*4+1
    rem_sh        = {in_data.rem, in_data.rad[SQ_V_W-1 -: 2]};
    trial         = (SQ_REM_W + 2)'({in_data.root, 2'b01});
    fits          = (rem_sh >= trial);
    data_nxt.sum  = in_data.sum;
    data_nxt.rad  = {in_data.rad[SQ_V_W-3:0], 2'b00};
    if (fits) begin
      data_nxt.rem  = SQ_REM_W'(rem_sh - trial);
      data_nxt.root = {in_data.root[SQ_K-2:0], 1'b1};
    end else begin
      data_nxt.rem  = SQ_REM_W'(rem_sh);
      data_nxt.root = {in_data.root[SQ_K-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign out_valid = valid_r;
  assign out_data  = data_r;

endmodule

`default_nettype wire

/* rtl/grfp_div_cell.sv */
`default_nettype none

module grfp_div_cell (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  grfp_pkg::div_data_t in_data,
  output logic                out_valid,
  output grfp_pkg::div_data_t out_data
);
  import grfp_pkg::*;

  logic [NUM_W-1:0] dsh_ext;
  logic             fits;
  div_data_t        data_nxt;
  logic             valid_r;
  div_data_t        data_r;

  always_comb begin
    dsh_ext      = NUM_W'(in_data.dsh);
    fits         = (in_data.rem >= dsh_ext);
    // the divisor walks down one bit position per cell
    data_nxt.dsh = in_data.dsh >> 1;
    if (fits) begin
      data_nxt.rem = in_data.rem - dsh_ext;
      data_nxt.quo = {in_data.quo[Q_W-2:0], 1'b1};
    end else begin
      data_nxt.rem = in_data.rem;
      data_nxt.quo = {in_data.quo[Q_W-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign out_valid = valid_r;
  assign out_data  = data_r;

endmodule

`default_nettype wire

/* rtl/gray_radial_fade_pixel_unit.sv */
`default_nettype none

// Radial fade gray pixel unit. Takes one RGB pixel with its column and row on
// every clock cycle (busy never rises) and returns the faded gray value as a
// one-cycle out_valid strobe; the receiver cannot stall the unit. Each pixel
// passes the square-root chain (one cell per root bit, SQ_K = COORD_BITS+9
// cells) and the eight-cell divider chain that forms the 8-bit quotient.
// Pixels at or beyond the radius, and every pixel when the radius is zero,
// give 0. Write center and radius only while no pixel is in flight.
module gray_radial_fade_pixel_unit (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  output logic                                busy,
  input  logic [grfp_pkg::CH_W-1:0]           in_red,
  input  logic [grfp_pkg::CH_W-1:0]           in_green,
  input  logic [grfp_pkg::CH_W-1:0]           in_blue,
  input  logic [grfp_pkg::COORD_BITS-1:0]     in_pos_x,
  input  logic [grfp_pkg::COORD_BITS-1:0]     in_pos_y,
  output logic                                out_valid,
  output logic [grfp_pkg::CH_W-1:0]           out_gray,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [grfp_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [grfp_pkg::CFG_DAT_W-1:0]      cfg_data
);
  import grfp_pkg::*;

  // configuration
  logic [CX_W-1:0]  center_x_r, center_x_nxt;
  logic [CX_W-1:0]  center_y_r, center_y_nxt;
  logic [RAD_W-1:0] fade_radius_r, fade_radius_nxt;
  logic             cfg_write;

  // front stages
  logic                  in_accept;
  logic [COORD_BITS-1:0] cx, cy;
  logic                  a_valid_r;
  logic [COORD_BITS-1:0] a_dx_r, a_dx_nxt;
  logic [COORD_BITS-1:0] a_dy_r, a_dy_nxt;
  logic [SUM_W-1:0]      a_sum_r, a_sum_nxt;
  logic                  b_valid_r;
  logic [SQR_W-1:0]      b_dx2_r, b_dx2_nxt;
  logic [SQR_W-1:0]      b_dy2_r, b_dy2_nxt;
  logic [SUM_W-1:0]      b_sum_r;
  logic                  c_valid_r;
  logic [D2_W-1:0]       c_d2_r, c_d2_nxt;
  logic [SUM_W-1:0]      c_sum_r;

  // cell chains
  logic      sq_valid [SQ_K+1];
  sq_data_t  sq_data  [SQ_K+1];
  logic      dv_valid [Q_W+1];
  div_data_t dv_data  [Q_W+1];

  // scale stage
  logic [SQ_K-1:0]  root;
  logic [RF_W-1:0]  rfix;
  logic [DEN_W-1:0] den;
  logic             in_fade;
  logic [RF_W-1:0]  fade;
  logic             m_valid_r;
  div_data_t        m_data_r, m_data_nxt;

  assign cfg_ready = 1'b1;
  assign cfg_write = cfg_valid & cfg_ready;
  assign busy      = 1'b0;
  assign in_accept = start & ~busy;

  always_comb begin
    center_x_nxt    = center_x_r;
    center_y_nxt    = center_y_r;
    fade_radius_nxt = fade_radius_r;
    if (cfg_write) begin
      case (cfg_index)
        REG_CENTER_X:    center_x_nxt    = cfg_data[CX_W-1:0];
        REG_CENTER_Y:    center_y_nxt    = cfg_data[CX_W-1:0];
        REG_FADE_RADIUS: fade_radius_nxt = cfg_data[RAD_W-1:0];
        default:         ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      center_x_r    <= '0;
      center_y_r    <= '0;
      fade_radius_r <= RAD_W'(1);
    end else begin
      center_x_r    <= center_x_nxt;
      center_y_r    <= center_y_nxt;
      fade_radius_r <= fade_radius_nxt;
    end
  end

  // stage A: channel sum and distance per axis
  always_comb begin
    cx        = COORD_BITS'(center_x_r);
    cy        = COORD_BITS'(center_y_r);
    a_dx_nxt  = (in_pos_x >= cx) ? (in_pos_x - cx) : (cx - in_pos_x);
    a_dy_nxt  = (in_pos_y >= cy) ? (in_pos_y - cy) : (cy - in_pos_y);
    a_sum_nxt = SUM_W'(in_red) + SUM_W'(in_green) + SUM_W'(in_blue);
  end

  // stage B: squares; stage C: squared distance
  always_comb begin
    b_dx2_nxt = SQR_W'(a_dx_r) * SQR_W'(a_dx_r);
    b_dy2_nxt = SQR_W'(a_dy_r) * SQR_W'(a_dy_r);
    c_d2_nxt  = D2_W'(b_dx2_r) + D2_W'(b_dy2_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
      b_valid_r <= 1'b0;
      c_valid_r <= 1'b0;
    end else begin
      a_valid_r <= in_accept;
      b_valid_r <= a_valid_r;
      c_valid_r <= b_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    a_dx_r  <= a_dx_nxt;
    a_dy_r  <= a_dy_nxt;
    a_sum_r <= a_sum_nxt;
    b_dx2_r <= b_dx2_nxt;
    b_dy2_r <= b_dy2_nxt;
    b_sum_r <= a_sum_r;
    c_d2_r  <= c_d2_nxt;
    c_sum_r <= b_sum_r;
  end

  // square root of d2 * 2^16, one root bit per cell
  assign sq_valid[0]     = c_valid_r;
  assign sq_data[0].rem  = '0;
  assign sq_data[0].root = '0;
  assign sq_data[0].rad  = SQ_V_W'({c_d2_r, {(2 * FRAC_BITS){1'b0}}});
  assign sq_data[0].sum  = c_sum_r;

  for (genvar i = 0; i < SQ_K; i++) begin : g_sqrt
    grfp_sqrt_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .in_valid  (sq_valid[i]),
      .in_data   (sq_data[i]),
      .out_valid (sq_valid[i+1]),
      .out_data  (sq_data[i+1])
    );
  end

  // scale stage: numerator sum*(rfix - s), divisor 3*rfix aligned to the top quotient bit
  always_comb begin
    root    = sq_data[SQ_K].root;
    rfix    = {fade_radius_r, {FRAC_BITS{1'b0}}};
    den     = DEN_W'(rfix) + DEN_W'({rfix, 1'b0});
    in_fade = (CMP_W'(root) < CMP_W'(rfix));
    fade    = RF_W'(CMP_W'(rfix) - CMP_W'(root));
    m_data_nxt.quo = '0;
    if (in_fade) begin
      m_data_nxt.rem = NUM_W'(sq_data[SQ_K].sum) * NUM_W'(fade);
      m_data_nxt.dsh = {den, {(Q_W - 1){1'b0}}};
    end else begin
      // force a zero quotient, also for a zero radius
      m_data_nxt.rem = '0;
      m_data_nxt.dsh = '1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m_valid_r <= 1'b0;
    end else begin
      m_valid_r <= sq_valid[SQ_K];
    end
  end

  always_ff @(posedge clk) begin
    m_data_r <= m_data_nxt;
  end

  // restoring division, one quotient bit per cell
  assign dv_valid[0] = m_valid_r;
  assign dv_data[0]  = m_data_r;

  for (genvar j = 0; j < Q_W; j++) begin : g_div
    grfp_div_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .in_valid  (dv_valid[j]),
      .in_data   (dv_data[j]),
      .out_valid (dv_valid[j+1]),
      .out_data  (dv_data[j+1])
    );
  end

  assign out_valid = dv_valid[Q_W];
  assign out_gray  = dv_data[Q_W].quo;

  a_fixed_latency: assert property (@(posedge clk) disable iff (!rst_n)
    in_accept |-> ##PIPE_LAT out_valid)
    else $error("accepted pixel did not come out after the pipeline latency");

  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(in_accept, PIPE_LAT))
    else $error("result strobe without a matching accepted pixel");

  a_outside_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (m_valid_r && (m_data_r.rem == '0)) |-> ##Q_W (out_gray == '0))
    else $error("pixel outside the radius gave a nonzero gray value");

endmodule

`default_nettype wire

/* dv/gray_radial_fade_pixel_unit_tb.sv */
`default_nettype none

module gray_radial_fade_pixel_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import grfp_pkg::*;

  localparam int CW        = COORD_BITS;
  localparam int RUN_LIMIT = 200000;
  // no register sits at this index, so a write here must change nothing
  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;

  typedef struct packed {
    logic [CH_W-1:0] red;
    logic [CH_W-1:0] green;
    logic [CH_W-1:0] blue;
    logic [CW-1:0]   pos_x;
    logic [CW-1:0]   pos_y;
  } pixel_t;

  typedef struct packed {
    pixel_t          px;
    logic [CH_W-1:0] gray;
  } gray_due_t;

  logic                 clk       = 1'b0;
  logic                 rst_n     = 1'b0;
  logic                 start     = 1'b0;
  logic                 busy;
  logic [CH_W-1:0]      in_red    = '0;
  logic [CH_W-1:0]      in_green  = '0;
  logic [CH_W-1:0]      in_blue   = '0;
  logic [CW-1:0]        in_pos_x  = '0;
  logic [CW-1:0]        in_pos_y  = '0;
  logic                 out_valid;
  logic [CH_W-1:0]      out_gray;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DAT_W-1:0] cfg_data  = '0;

  // mirror of the configuration registers
  logic [CX_W-1:0]  cen_x    = '0;
  logic [CX_W-1:0]  cen_y    = '0;
  logic [RAD_W-1:0] fade_rad = 13'd1;

  pixel_t      pixel_backlog[$];
  gray_due_t   gray_due[$];
  logic        in_took     = 1'b0;
  int          idle_left   = 0;
  int          gap_max     = 0;
  int          mismatches  = 0;
  int          grays_seen  = 0;
  int unsigned cycle_count = 0;

  gray_radial_fade_pixel_unit u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_red    (in_red),
    .in_green  (in_green),
    .in_blue   (in_blue),
    .in_pos_x  (in_pos_x),
    .in_pos_y  (in_pos_y),
    .out_valid (out_valid),
    .out_gray  (out_gray),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #1 clk = ~clk;

  function automatic logic [63:0] int_sqrt(logic [63:0] v);
    logic [63:0] root;
    logic [63:0] trial;
    root = '0;
    for (int b = 31; b >= 0; b--) begin
      trial = root | (64'd1 << b);
      if (trial * trial <= v) root = trial;
    end
    return root;
  endfunction

  function automatic logic [CH_W-1:0] faded_gray(pixel_t p);
    logic [63:0] sum;
    logic [63:0] dx;
    logic [63:0] dy;
    logic [63:0] dist_fix;
    logic [63:0] rad_fix;
    logic [63:0] gray;
    sum = 64'(p.red) + 64'(p.green) + 64'(p.blue);
    dx = (p.pos_x >= cen_x) ? 64'(p.pos_x - cen_x) : 64'(cen_x - p.pos_x);
    dy = (p.pos_y >= cen_y) ? 64'(p.pos_y - cen_y) : 64'(cen_y - p.pos_y);
    dist_fix = int_sqrt((dx * dx + dy * dy) << 16);
    rad_fix = 64'(fade_rad) << FRAC_BITS;
    gray = '0;
    // at or past the radius (and for a zero radius) the fade is clamped to zero
    if (dist_fix < rad_fix) gray = (sum * (rad_fix - dist_fix)) / (64'd3 * rad_fix);
    return gray[CH_W-1:0];
  endfunction

  function automatic logic [CH_W-1:0] rand_chan();
    if ($urandom_range(0, 9) == 0) return $urandom_range(0, 1) ? 8'hFF : 8'h00;
    return CH_W'($urandom);
  endfunction

  // land near the center so the fade slope is exercised, wrapping at the edges
  function automatic logic [CW-1:0] near_coord(logic [CX_W-1:0] c);
    int span;
    int off;
    span = (int'(fade_rad) * 5) / 4 + 2;
    if (span > 4095) span = 4095;
    off = $urandom_range(0, 2 * span);
    return CW'(int'(c) + off - span);
  endfunction

  function automatic pixel_t rand_pixel();
    pixel_t p;
    p.red   = rand_chan();
    p.green = rand_chan();
    p.blue  = rand_chan();
    if ($urandom_range(0, 3) != 0) begin
      p.pos_x = near_coord(cen_x);
      p.pos_y = near_coord(cen_y);
    end else begin
      p.pos_x = CW'($urandom);
      p.pos_y = CW'($urandom);
    end
    return p;
  endfunction

  function automatic void add_pixel(int r, int g, int b, int x, int y);
    pixel_t p;
    p.red   = CH_W'(r);
    p.green = CH_W'(g);
    p.blue  = CH_W'(b);
    p.pos_x = CW'(x);
    p.pos_y = CW'(y);
    pixel_backlog.push_back(p);
  endfunction

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DAT_W-1:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    case (idx)
      REG_CENTER_X:    cen_x = val[CX_W-1:0];
      REG_CENTER_Y:    cen_y = val[CX_W-1:0];
      REG_FADE_RADIUS: fade_rad = val[RAD_W-1:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // check at the rising edge, where the backlog and start are settled
  task automatic wait_drained();
    do @(posedge clk);
    while (pixel_backlog.size() != 0 || start || gray_due.size() != 0);
  endtask

  // driver: hold a transaction until taken, then advance after a random gap
  always @(negedge clk) begin : drive_pixels
    pixel_t nxt;
    if (!rst_n) begin
      start <= 1'b0;
    end else if (!start || in_took) begin
      if (pixel_backlog.size() != 0 && idle_left == 0) begin
        nxt = pixel_backlog.pop_front();
        in_red    <= nxt.red;
        in_green  <= nxt.green;
        in_blue   <= nxt.blue;
        in_pos_x  <= nxt.pos_x;
        in_pos_y  <= nxt.pos_y;
        start     <= 1'b1;
        idle_left <= $urandom_range(0, gap_max);
      end else begin
        // scramble the fields while idle; the unit must ignore them
        in_red   <= CH_W'($urandom);
        in_green <= CH_W'($urandom);
        in_blue  <= CH_W'($urandom);
        in_pos_x <= CW'($urandom);
        in_pos_y <= CW'($urandom);
        start    <= 1'b0;
        if (idle_left != 0) idle_left <= idle_left - 1;
      end
    end
  end

  always @(posedge clk) begin : check_gray
    pixel_t    px;
    gray_due_t due;
    px = '{in_red, in_green, in_blue, in_pos_x, in_pos_y};
    in_took <= rst_n && start && !busy;
    if (rst_n && start && !busy) gray_due.push_back('{px, faded_gray(px)});
    if (rst_n && out_valid !== 1'b0) begin
      grays_seen++;
      if (out_valid !== 1'b1 || gray_due.size() == 0) begin
        if (mismatches < 10)
          $display("gray #%0d: unexpected strobe (out_valid=%b, gray=%0d)",
                   grays_seen, out_valid, out_gray);
        mismatches++;
      end else begin
        due = gray_due.pop_front();
        if (out_gray !== due.gray) begin
          if (mismatches < 10)
            $display("gray #%0d: rgb=%0d,%0d,%0d at (%0d,%0d): expected %0d, got %0d",
                     grays_seen, due.px.red, due.px.green, due.px.blue,
                     due.px.pos_x, due.px.pos_y, due.gray, out_gray);
          mismatches++;
        end
      end
    end
  end

  always @(posedge clk) begin : watchdog
    cycle_count <= cycle_count + 1;
    if (cycle_count == RUN_LIMIT) begin
      $display("FAIL gray_radial_fade_pixel_unit");
      $finish;
    end
  end

  initial begin : stimulus
    logic [RAD_W-1:0] rad;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // reset values: center at the origin, radius of one pixel
    gap_max = 0;
    @(posedge clk);
    add_pixel(255, 255, 255, 0, 0);
    add_pixel(0, 0, 0, 0, 0);
    add_pixel(255, 0, 0, 0, 0);
    add_pixel(1, 1, 1, 1, 0);
    add_pixel(255, 255, 255, 4095, 4095);
    wait_drained();

    // far corner center with the widest radius
    write_reg(REG_CENTER_X, 13'd4095);
    write_reg(REG_CENTER_Y, 13'd4095);
    write_reg(REG_FADE_RADIUS, 13'd8191);
    gap_max = 7;
    @(posedge clk);
    add_pixel(255, 255, 255, 0, 0);
    add_pixel(255, 255, 255, 4095, 4095);
    add_pixel(0, 255, 0, 0, 4095);
    add_pixel(255, 255, 255, 2048, 1);
    add_pixel(8'hAA, 8'h55, 8'hAA, 12'hAAA, 12'h555);
    add_pixel(8'h55, 8'hAA, 8'h55, 12'h555, 12'hAAA);
    wait_drained();

    // oversized center data gets masked; a zero radius blanks every pixel
    write_reg(REG_CENTER_X, 13'h1FFF);
    write_reg(REG_CENTER_Y, 13'd0);
    write_reg(REG_FADE_RADIUS, 13'd0);
    write_reg(REG_SPARE, 13'h1555);
    @(posedge clk);
    add_pixel(255, 255, 255, 4095, 0);
    add_pixel(200, 100, 50, 4000, 10);
    wait_drained();

    // small radius: on and inside the boundary
    write_reg(REG_CENTER_X, 13'd100);
    write_reg(REG_CENTER_Y, 13'd100);
    write_reg(REG_FADE_RADIUS, 13'd3);
    gap_max = 3;
    @(posedge clk);
    add_pixel(255, 255, 255, 103, 100);
    add_pixel(255, 255, 255, 102, 102);
    add_pixel(255, 255, 255, 100, 97);
    add_pixel(255, 255, 254, 101, 100);
    wait_drained();

    for (int ph = 0; ph < 10; ph++) begin
      case (ph)
        0:       rad = 13'd8191;
        1:       rad = 13'd1;
        2:       rad = 13'd2;
        default: begin
          if ($urandom_range(0, 15) == 0) rad = 13'd0;
          else if ($urandom_range(0, 2) == 0) rad = RAD_W'($urandom_range(200, 8191));
          else rad = RAD_W'($urandom_range(1, 200));
        end
      endcase
      write_reg(REG_FADE_RADIUS, rad);
      write_reg(REG_CENTER_X, CFG_DAT_W'($urandom));
      write_reg(REG_CENTER_Y, CFG_DAT_W'($urandom));
      if (ph % 3 == 0) write_reg(REG_SPARE, CFG_DAT_W'($urandom));
      gap_max = (ph % 3 == 1) ? 0 : 7;
      @(posedge clk);
      repeat (110) pixel_backlog.push_back(rand_pixel());
      wait_drained();
    end

    repeat (PIPE_LAT + 8) @(posedge clk);
    if (mismatches == 0 && gray_due.size() == 0) begin
      $display("PASS gray_radial_fade_pixel_unit");
    end else begin
      $display("FAIL gray_radial_fade_pixel_unit");
    end
    $finish;
  end

endmodule

`default_nettype wire

/* filelist.f */
rtl/grfp_pkg.sv
rtl/grfp_sqrt_cell.sv
rtl/grfp_div_cell.sv
rtl/gray_radial_fade_pixel_unit.sv
dv/gray_radial_fade_pixel_unit_tb.sv
